@@ src/uvs_pkg.sv @@
// Shared types and constants for the UV sphere grid point pipeline.
`timescale 1ns / 1ps

package uvs_pkg;

    typedef logic [10:0] count_t;

    // Register indexes on the configuration port.
    localparam logic REG_FACES_AROUND      = 1'b0;
    localparam logic REG_FACES_POLE_TO_POLE = 1'b1;

    // Restoring divider: 25 fraction bits, quotient up to 2^25.
    localparam int DIV_STEPS = 25;
    localparam int QUO_W     = DIV_STEPS + 1;

    // Sine core: reduce, square, five Horner steps, final multiply.
    localparam int SINE_STAGES = 8;
    localparam int PHASE_W     = 24;
    localparam logic [PHASE_W-1:0] Q_QUARTER = 24'h400000;

    localparam logic [30:0] C11 = 31'd3864;
    localparam logic [30:0] HORNER_C [5] = '{
        31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
    };

    typedef struct packed {
        logic [10:0] column;
        logic [10:0] row;
    } in_word_t;

    typedef struct packed {
        logic [20:0]        slot_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic               has_position;
        logic               has_face;
        logic [20:0]        corner_c_pos;
        logic [20:0]        corner_d_pos;
        logic [20:0]        corner_c_tex;
        logic [20:0]        corner_d_tex;
    } out_word_t;

endpackage

@@ src/uvs_pipe_ctrl.sv @@
// Per-stage valid bits and load enables for the elastic pipeline.
`timescale 1ns / 1ps

module uvs_pipe_ctrl #(
    parameter int DEPTH = 36
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             out_stall,
    output logic [DEPTH-1:0] en,
    output logic [DEPTH-1:0] valid
);

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [DEPTH-1:0] ready;

    // A stage may load when any stage at or after it holds a bubble,
    // or when the output side takes a word.
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            ready[k] = !out_stall || ((~valid_reg & ({DEPTH{1'b1}} << k)) != '0);
        end
    end

    assign valid_next = {valid_reg[DEPTH-2:0], in_valid};
    assign en         = ready;
    assign valid      = valid_reg;
    assign in_stall   = !ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[DEPTH-1] && out_stall |=> valid_reg[DEPTH-1])
        else $error("stalled output word dropped");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && ready[0] |-> ready[1])
        else $error("first stage overwritten while next stage holds");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> valid_reg[0])
        else $error("accepted word missing from first stage");

    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> (&ready))
        else $error("stage blocked while output drains");

endmodule

@@ src/uvs_divider.sv @@
// Pipelined restoring divider: floor(num * 2^25 / den), one bit per stage.
`timescale 1ns / 1ps

module uvs_divider
    import uvs_pkg::*;
(
    input  logic                 clk,
    input  logic [DIV_STEPS-1:0] en,
    input  count_t               num,
    input  count_t               den,
    output logic [QUO_W-1:0]     quo
);

    count_t           rem_reg [DIV_STEPS];
    count_t           den_reg [DIV_STEPS];
    logic [QUO_W-1:0] quo_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        count_t           rem_in;
        count_t           den_in;
        logic [QUO_W-1:0] quo_in;
        logic [11:0]      rem2;
        logic             ge;

        if (k == 0)
        begin : g_first
            // num >= den only for the seam column (exact 2^25) or off-grid points
            assign rem_in = (num >= den) ? '0 : num;
            assign quo_in = QUO_W'(num >= den);
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        assign rem2 = {rem_in, 1'b0};
        assign ge   = rem2 >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k] <= ge ? 11'(rem2 - {1'b0, den_in}) : rem2[10:0];
                den_reg[k] <= den_in;
                quo_reg[k] <= {quo_in[QUO_W-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

@@ src/uvs_sine.sv @@
// Pipelined Q30 sine of a 24-bit turn phase, odd polynomial on a quarter wave.
`timescale 1ns / 1ps

module uvs_sine
    import uvs_pkg::*;
(
    input  logic                   clk,
    input  logic [SINE_STAGES-1:0] en,
    input  logic [PHASE_W-1:0]     phase,
    output logic [31:0]            mag,
    output logic                   neg
);

    logic [30:0] t_reg   [0:6];
    logic [30:0] t2_reg  [1:5];
    logic [30:0] s_reg   [2:6];
    logic        neg_reg [0:7];
    logic [31:0] mag_reg;

    logic [22:0] r_fold;
    logic [61:0] sq_prod;
    logic [61:0] fin_prod;

    // odd quadrants run the quarter wave backwards
    assign r_fold   = phase[22] ? (23'h400000 - {1'b0, phase[21:0]}) : {1'b0, phase[21:0]};
    assign sq_prod  = t_reg[0] * t_reg[0];
    assign fin_prod = s_reg[6] * t_reg[6];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t_reg[0]   <= {r_fold, 8'b0};
            neg_reg[0] <= phase[23];
        end
        if (en[1])
        begin
            t2_reg[1] <= sq_prod[60:30];
        end
        if (en[7])
        begin
            mag_reg <= fin_prod[61:30];
        end
    end

    for (genvar k = 1; k < 8; k++)
    begin : g_carry
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                neg_reg[k] <= neg_reg[k-1];
            end
        end
        if (k < 7)
        begin : g_t
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    t_reg[k] <= t_reg[k-1];
                end
            end
        end
        if (k >= 2 && k < 6)
        begin : g_t2
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    t2_reg[k] <= t2_reg[k-1];
                end
            end
        end
    end

    for (genvar k = 2; k < 7; k++)
    begin : g_horner
        logic [30:0] s_in;
        logic [61:0] prod;

        if (k == 2)
        begin : g_first
            assign s_in = C11;
        end
        else
        begin : g_rest
            assign s_in = s_reg[k-1];
        end

        assign prod = s_in * t2_reg[k-1];

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                s_reg[k] <= HORNER_C[k-2] - prod[60:30];
            end
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg[7];

endmodule

@@ src/uv_sphere_grid_point.sv @@
// UV sphere grid point: slot, unit position, texture coordinate and quad corners.
// Stages from input accept to output word: 25 divider stages, one phase stage,
// 8 sine stages, multiply and round stages.
// Throughput: one word per cycle unless the output stalls; a stage loads when
// it or a later stage holds a bubble, so gaps are squeezed out in a stall.
// Reset clears all valid bits and loads faces_around 16, faces_pole_to_pole 8.
`timescale 1ns / 1ps

module uv_sphere_grid_point
    import uvs_pkg::*;
#(
    parameter int MAX_FACES = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  count_t    cfg_data
);

    localparam int P_S   = DIV_STEPS;
    localparam int X1_S  = P_S + SINE_STAGES + 1;
    localparam int OUT_S = X1_S + 1;
    localparam int DEPTH = OUT_S + 1;

    typedef struct packed {
        count_t i;
        count_t j;
        count_t u;
        count_t v;
    } a_t;

    typedef struct packed {
        logic [20:0] slot;
        logic [15:0] tex_u;
        logic [15:0] tex_v;
        logic        has_pos;
        logic        has_face;
        logic        last_col;
        count_t      j;
        count_t      v;
    } b_t;

    typedef struct packed {
        logic [63:0] prod_x;
        logic [63:0] prod_y;
        logic [31:0] ct;
        logic        neg_x;
        logic        neg_y;
        logic        neg_z;
        logic [20:0] slot;
        logic [15:0] tex_u;
        logic [15:0] tex_v;
        logic        has_pos;
        logic        has_face;
        logic [20:0] c_pos;
        logic [20:0] d_pos;
        logic [20:0] c_tex;
        logic [20:0] d_tex;
    } x1_t;

    function automatic count_t clamp_count(count_t n);
        count_t r;
        r = n;
        if (n == '0)
        begin
            r = 11'd1;
        end
        else if (32'(n) > MAX_FACES)
        begin
            r = 11'(MAX_FACES);
        end
        return r;
    endfunction

    function automatic logic signed [15:0] to_q14(logic [17:0] mag, logic neg);
        logic [15:0] m;
        m = (mag > 18'd16384) ? 16'd16384 : mag[15:0];
        return neg ? $signed(16'd0 - m) : $signed(m);
    endfunction

    count_t faces_around_reg;
    count_t faces_pole_to_pole_reg;
    count_t u_eff;
    count_t v_eff;

    logic [DEPTH-1:0] en;
    logic [DEPTH-1:0] valid;

    logic [QUO_W-1:0] quo_l;
    logic [QUO_W-1:0] quo_t;

    a_t a_reg [DIV_STEPS];
    b_t b_reg [SINE_STAGES+1];
    b_t b_next;
    logic [PHASE_W-1:0] pl_reg, plq_reg, pt_reg, ptq_reg;
    logic [PHASE_W-1:0] pl_next, pt_next;

    logic [31:0] mag_sl, mag_cl, mag_st, mag_ct;
    logic        neg_sl, neg_cl, neg_st, neg_ct;

    x1_t       x1_reg;
    x1_t       x1_next;
    out_word_t out_reg;
    out_word_t out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            faces_around_reg       <= 11'd16;
            faces_pole_to_pole_reg <= 11'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FACES_AROUND:       faces_around_reg       <= cfg_data;
                REG_FACES_POLE_TO_POLE: faces_pole_to_pole_reg <= cfg_data;
                default:                faces_around_reg       <= faces_around_reg;
            endcase
        end
    end

    assign u_eff = clamp_count(faces_around_reg);
    assign v_eff = clamp_count(faces_pole_to_pole_reg);

    uvs_pipe_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .en        (en),
        .valid     (valid)
    );

    uvs_divider u_div_lon (
        .clk (clk),
        .en  (en[DIV_STEPS-1:0]),
        .num (in_word.column),
        .den (u_eff),
        .quo (quo_l)
    );

    uvs_divider u_div_lat (
        .clk (clk),
        .en  (en[DIV_STEPS-1:0]),
        .num (in_word.row),
        .den (v_eff),
        .quo (quo_t)
    );

    // side data riding along the dividers
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_reg[0] <= '{i: in_word.column, j: in_word.row, u: u_eff, v: v_eff};
        end
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            if (en[k])
            begin
                a_reg[k] <= a_reg[k-1];
            end
        end
    end

    // phase stage: rounding of quotients, slot, flags
    always_comb
    begin
        a_t          a;
        logic        off;
        logic [21:0] prod_s;
        logic [QUO_W:0] ql1;
        logic [QUO_W-1:0] qt1;
        logic [17:0] tu;
        logic [17:0] tv;

        a       = a_reg[DIV_STEPS-1];
        ql1     = {1'b0, quo_l} + 1'b1;
        pl_next = ql1[PHASE_W:1];
        qt1     = {1'b0, quo_t[QUO_W-1:1]} + 1'b1;
        pt_next = qt1[PHASE_W:1];
        tu      = ({1'b0, quo_l[QUO_W-1:9]} + 18'd1) >> 1;
        tv      = ({1'b0, quo_t[QUO_W-1:9]} + 18'd1) >> 1;
        off     = (a.i > a.u) || (a.j > a.v);
        prod_s  = a.i * (12'(a.v) + 12'd1);

        b_next.slot     = off ? '0 : 21'(prod_s + 22'(a.j));
        b_next.tex_u    = off ? '0 : tu[15:0];
        b_next.tex_v    = off ? '0 : 16'(18'd32768 - tv);
        b_next.has_pos  = !off && (a.i < a.u);
        b_next.has_face = !off && (a.i < a.u) && (a.j < a.v);
        b_next.last_col = a.i == 11'(a.u - 11'd1);
        b_next.j        = a.j;
        b_next.v        = a.v;
    end

    always_ff @(posedge clk)
    begin
        if (en[P_S])
        begin
            pl_reg   <= pl_next;
            plq_reg  <= pl_next + Q_QUARTER;
            pt_reg   <= pt_next;
            ptq_reg  <= pt_next + Q_QUARTER;
            b_reg[0] <= b_next;
        end
        for (int m = 1; m <= SINE_STAGES; m++)
        begin
            if (en[P_S+m])
            begin
                b_reg[m] <= b_reg[m-1];
            end
        end
    end

    uvs_sine u_sin_lon (
        .clk (clk), .en (en[P_S+1 +: SINE_STAGES]), .phase (pl_reg),
        .mag (mag_sl), .neg (neg_sl)
    );

    uvs_sine u_cos_lon (
        .clk (clk), .en (en[P_S+1 +: SINE_STAGES]), .phase (plq_reg),
        .mag (mag_cl), .neg (neg_cl)
    );

    uvs_sine u_sin_lat (
        .clk (clk), .en (en[P_S+1 +: SINE_STAGES]), .phase (pt_reg),
        .mag (mag_st), .neg (neg_st)
    );

    uvs_sine u_cos_lat (
        .clk (clk), .en (en[P_S+1 +: SINE_STAGES]), .phase (ptq_reg),
        .mag (mag_ct), .neg (neg_ct)
    );

    // product stage and corner sums
    always_comb
    begin
        b_t          b;
        logic [20:0] c3;
        logic [20:0] c2;

        b  = b_reg[SINE_STAGES];
        c3 = b.slot + 21'(b.v) + 21'd3;
        c2 = b.slot + 21'(b.v) + 21'd2;

        x1_next.prod_x   = mag_cl * mag_st;
        x1_next.prod_y   = mag_sl * mag_st;
        x1_next.ct       = mag_ct;
        x1_next.neg_x    = neg_cl ^ neg_st;
        x1_next.neg_y    = neg_sl ^ neg_st;
        x1_next.neg_z    = neg_ct;
        x1_next.slot     = b.slot;
        x1_next.tex_u    = b.tex_u;
        x1_next.tex_v    = b.tex_v;
        x1_next.has_pos  = b.has_pos;
        x1_next.has_face = b.has_face;
        // last column wraps the position corners back to column zero
        x1_next.c_pos    = b.last_col ? (21'(b.j) + 21'd2) : c3;
        x1_next.d_pos    = b.last_col ? (21'(b.j) + 21'd1) : c2;
        x1_next.c_tex    = c3;
        x1_next.d_tex    = c2;
    end

    always_ff @(posedge clk)
    begin
        if (en[X1_S])
        begin
            x1_reg <= x1_next;
        end
    end

    // round, limit and gate
    always_comb
    begin
        logic [63:0] rx;
        logic [63:0] ry;
        logic [32:0] rz;

        rx = x1_reg.prod_x + (64'd1 << 45);
        ry = x1_reg.prod_y + (64'd1 << 45);
        rz = {1'b0, x1_reg.ct} + 33'h8000;

        out_next.slot_index   = x1_reg.slot;
        out_next.tex_u        = x1_reg.tex_u;
        out_next.tex_v        = x1_reg.tex_v;
        out_next.has_position = x1_reg.has_pos;
        out_next.has_face     = x1_reg.has_face;
        if (x1_reg.has_pos)
        begin
            out_next.pos_x = to_q14(rx[63:46], x1_reg.neg_x);
            out_next.pos_y = to_q14(ry[63:46], x1_reg.neg_y);
            out_next.pos_z = to_q14({1'b0, rz[32:16]}, x1_reg.neg_z);
        end
        else
        begin
            out_next.pos_x = '0;
            out_next.pos_y = '0;
            out_next.pos_z = '0;
        end
        if (x1_reg.has_face)
        begin
            out_next.corner_c_pos = x1_reg.c_pos;
            out_next.corner_d_pos = x1_reg.d_pos;
            out_next.corner_c_tex = x1_reg.c_tex;
            out_next.corner_d_tex = x1_reg.d_tex;
        end
        else
        begin
            out_next.corner_c_pos = '0;
            out_next.corner_d_pos = '0;
            out_next.corner_c_tex = '0;
            out_next.corner_d_tex = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[OUT_S])
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = valid[OUT_S];
    assign out_word  = out_reg;

endmodule
